@@ src/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg: shared types and codes for the trailer signature splitter
// Holds the request and result codes and the result word layout.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 8;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int STATUS_W    = 3;

    // request codes carried on the input tuser; the fourth code is ignored
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_END   = 2'd1,
        MODE_DRAIN = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_RELEASED  = 2'd0,
        KIND_IMAGE     = 2'd1,
        KIND_SIGNATURE = 2'd2,
        KIND_STATUS    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_REFUSED   = 3'd4
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  byte_out;
        t_status            status;
        logic [LEN_W-1:0]   sig_len;
        logic [LEN_W-1:0]   img_len;
        logic               last;
    } t_result;

    // result in flight between the store read and the output queue
    typedef struct packed {
        logic    use_mem;
        t_result res;
    } t_s1;

endpackage

@@ src/trailer_signature_splitter.sv @@
// ----------------------------------------------------------------------------
// trailer_signature_splitter
// Holds back the newest TAIL_DEPTH bytes of a stream in a ring store, checks
// the 2-byte big-endian trailer length at end of stream and drains the held
// image and signature bytes on request.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                                   | tuser  | tlast
//  s_axis    | in  | data_byte[7:0]                          | mode   | -
//  m_axis    | out | byte_out, status, sig_len, img_len      | kind   | last
//  i_cfg_*   | in  | max_signature_length[7:0], write only   | -      | -
//
//  One word per cycle on the input. A word touches the single ring store
//  once (a write, a read, or a read-first write of the oldest slot when a
//  push finds the store full) and all bookkeeping is done in the accept
//  cycle. A result passes the read stage, which holds the synchronous
//  store read, and then the four-entry output queue on its way to
//  m_axis. The input stalls only when that queue and the read stage
//  together hold four results. Reset clears the bookkeeping at once;
//  the store itself is not cleared.
// ----------------------------------------------------------------------------
module trailer_signature_splitter #(
    parameter int TAIL_DEPTH = 160
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tss_pkg::LEN_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tss_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [tss_pkg::S_TUSER_W-1:0]   s_axis_tuser,   // [1:0] mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] byte_out, [10:8] status, [18:11] signature_length,
    // [26:19] image_tail_length, [31:27] zero
    output logic [tss_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [tss_pkg::M_TUSER_W-1:0]   m_axis_tuser,   // [1:0] kind
    output logic                            m_axis_tlast
);
    import tss_pkg::*;

    localparam int AW = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
    localparam int CW = $clog2(TAIL_DEPTH + 1);
    localparam int CMP_W = 17;

    typedef enum logic {PH_STREAM, PH_DRAIN} t_phase;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(off);
        if (sum >= (AW+1)'(TAIL_DEPTH)) begin
            sum = sum - (AW+1)'(TAIL_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // ring store
    logic [BYTE_W-1:0] r_mem [TAIL_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata;

    // bookkeeping
    t_phase            r_phase, n_phase;
    logic [CW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_oldest, n_oldest;
    logic [CW-1:0]     r_drain_idx, n_drain_idx;
    logic [LEN_W-1:0]  r_sig_len, n_sig_len;
    logic [LEN_W-1:0]  r_img_len, n_img_len;
    logic [LEN_W-1:0]  r_max_len;
    logic [BYTE_W-1:0] r_newest0, n_newest0;     // last pushed byte
    logic [BYTE_W-1:0] r_newest1, n_newest1;     // the one before it

    // read stage and output queue
    logic              r_s1_valid, n_s1_valid;
    t_s1               r_s1, n_s1;
    t_result           r_fifo [4];
    logic [1:0]        r_wr_ptr, r_rd_ptr;
    logic [2:0]        r_fifo_cnt;
    t_result           s1_res;

    logic              in_acc, out_pop;
    t_mode             mode;
    logic [15:0]       foot_len;
    logic [CMP_W-1:0]  fill_x, len_x;
    logic [9:0]        total_x, idx_x;

    assign s_axis_tready = (3'(r_fifo_cnt) + 3'(r_s1_valid)) <= 3'd3;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign mode          = t_mode'(s_axis_tuser);

    assign foot_len = {r_newest1, r_newest0};
    assign fill_x   = CMP_W'(r_fill);
    assign len_x    = CMP_W'(foot_len);
    assign total_x  = 10'(r_sig_len) + 10'(r_img_len);
    assign idx_x    = 10'(r_drain_idx);

    always_comb begin
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_drain_idx = r_drain_idx;
        n_sig_len   = r_sig_len;
        n_img_len   = r_img_len;
        n_newest0   = r_newest0;
        n_newest1   = r_newest1;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_oldest;
        mem_raddr   = r_oldest;
        mem_wdata   = s_axis_tdata;
        n_s1_valid  = 1'b0;
        n_s1        = '0;
        n_s1.res.kind   = KIND_STATUS;
        n_s1.res.status = ST_OK;

        if (in_acc) begin
            unique case (mode)
                MODE_PUSH: begin
                    if (r_phase == PH_DRAIN) begin
                        n_s1_valid      = 1'b1;
                        n_s1.res.status = ST_REFUSED;
                    end else begin
                        n_newest0 = s_axis_tdata;
                        n_newest1 = r_newest0;
                        mem_we    = 1'b1;
                        if (r_fill < CW'(TAIL_DEPTH)) begin
                            mem_waddr = ring_addr(r_oldest, r_fill);
                            n_fill    = r_fill + CW'(1);
                        end else begin
                            // full: read-first on the same slot releases the oldest
                            mem_waddr     = r_oldest;
                            mem_re        = 1'b1;
                            n_s1_valid    = 1'b1;
                            n_s1.use_mem  = 1'b1;
                            n_s1.res.kind = KIND_RELEASED;
                            n_oldest      = (r_oldest == AW'(TAIL_DEPTH - 1)) ?
                                            '0 : r_oldest + AW'(1);
                        end
                    end
                end
                MODE_END: begin
                    n_s1_valid = 1'b1;
                    if (r_phase == PH_DRAIN) begin
                        n_s1.res.status = ST_REFUSED;
                    end else if (r_fill < CW'(2)) begin
                        n_s1.res.status = ST_TOO_SHORT;
                        n_phase = PH_STREAM;
                        n_fill = '0; n_oldest = '0; n_drain_idx = '0;
                        n_sig_len = '0; n_img_len = '0;
                    end else if (foot_len == 16'd0 ||
                                 foot_len > 16'(r_max_len) ||
                                 len_x + CMP_W'(2) > fill_x) begin
                        n_s1.res.status = ST_MALFORMED;
                        n_phase = PH_STREAM;
                        n_fill = '0; n_oldest = '0; n_drain_idx = '0;
                        n_sig_len = '0; n_img_len = '0;
                    end else begin
                        n_sig_len   = foot_len[LEN_W-1:0];
                        n_img_len   = LEN_W'(fill_x - CMP_W'(2) - len_x);
                        n_drain_idx = '0;
                        n_phase     = PH_DRAIN;
                        n_s1.res.sig_len = foot_len[LEN_W-1:0];
                        n_s1.res.img_len = LEN_W'(fill_x - CMP_W'(2) - len_x);
                    end
                end
                MODE_DRAIN: begin
                    n_s1_valid = 1'b1;
                    if (r_phase != PH_DRAIN) begin
                        n_s1.res.status = ST_EMPTY;
                    end else begin
                        mem_re       = 1'b1;
                        mem_raddr    = ring_addr(r_oldest, r_drain_idx);
                        n_s1.use_mem = 1'b1;
                        if (idx_x < 10'(r_img_len)) begin
                            n_s1.res.kind = KIND_IMAGE;
                            n_drain_idx   = r_drain_idx + CW'(1);
                        end else if (idx_x + 10'd1 >= total_x) begin
                            n_s1.res.kind = KIND_SIGNATURE;
                            n_s1.res.last = 1'b1;
                            n_phase = PH_STREAM;
                            n_fill = '0; n_oldest = '0; n_drain_idx = '0;
                            n_sig_len = '0; n_img_len = '0;
                        end else begin
                            n_s1.res.kind = KIND_SIGNATURE;
                            n_drain_idx   = r_drain_idx + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STREAM;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_drain_idx <= '0;
            r_sig_len   <= '0;
            r_img_len   <= '0;
            r_max_len   <= LEN_W'(96);
            r_s1_valid  <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fifo_cnt  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_drain_idx <= n_drain_idx;
            r_sig_len   <= n_sig_len;
            r_img_len   <= n_img_len;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_s1_valid  <= n_s1_valid;
            if (r_s1_valid) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_fifo_cnt <= r_fifo_cnt + 3'(r_s1_valid) - 3'(out_pop);
        end
    end

    always_comb begin
        s1_res          = r_s1.res;
        s1_res.byte_out = r_s1.use_mem ? r_rd_data : '0;
    end

    always_ff @(posedge i_clk) begin
        r_newest0 <= n_newest0;
        r_newest1 <= n_newest1;
        r_s1      <= n_s1;
        if (r_s1_valid) begin
            r_fifo[r_wr_ptr] <= s1_res;
        end
    end

    assign m_axis_tvalid = (r_fifo_cnt != 3'd0);
    assign m_axis_tdata  = {5'd0, r_fifo[r_rd_ptr].img_len, r_fifo[r_rd_ptr].sig_len,
                            r_fifo[r_rd_ptr].status, r_fifo[r_rd_ptr].byte_out};
    assign m_axis_tuser  = r_fifo[r_rd_ptr].kind;
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

    // queue plus read stage never exceed the queue depth
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (4'(r_fifo_cnt) + 4'(r_s1_valid)) <= 4'd4)
        else $error("output queue overflow");

    // while draining the held lengths and the two footer bytes account for every held byte
    a_drain_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DRAIN |->
            (10'(r_sig_len) + 10'(r_img_len) + 10'd2 == 10'(r_fill))
            && (10'(r_drain_idx) < 10'(r_sig_len) + 10'(r_img_len)))
        else $error("drain bookkeeping inconsistent");

    // a refused push leaves the store untouched
    a_refused_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_DRAIN && s_axis_tuser == MODE_PUSH) |=>
            $stable(r_fill) && $stable(r_oldest))
        else $error("refused push changed the store");

    // the final-word flag only rides on a signature byte
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser == KIND_SIGNATURE)
        else $error("last set on a non-signature word");

    // a successful end always enters the drain phase
    a_end_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.res.kind == KIND_STATUS && r_s1.res.status == ST_OK)
            |-> r_phase == PH_DRAIN)
        else $error("accepted footer without drain phase");

endmodule

@@ sim/trailer_signature_splitter_tb.sv @@
// ----------------------------------------------------------------------------
// trailer_signature_splitter_tb: self-checking bench for the trailer splitter
// Drives image/signature/footer streams with end and drain requests, predicts
// every result word in step with the accepted input and checks the output
// stream in order, under random source and sink idling and one long sink hold.
// ----------------------------------------------------------------------------
module trailer_signature_splitter_tb;
    import tss_pkg::*;

    localparam int DEPTH       = 160;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 400000;
    localparam int SHOW_MAX    = 10;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] data;
    } t_stream_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;   // [1:0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] byte_out, [10:8] status, [18:11] sig len, [26:19] image tail len
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;        // [1:0] kind
    logic                  m_axis_tlast;

    trailer_signature_splitter #(.TAIL_DEPTH(DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_stream_word stream_words[$];
    t_result      pending_results[$];
    t_stream_word next_word;
    t_result      want;

    // predicted splitter state
    logic [7:0] held_bytes [DEPTH];
    int         held_cnt = 0;
    int         head_ptr = 0;
    bit         draining = 1'b0;
    int         drain_pos = 0;
    int         sig_hold = 0;
    int         img_hold = 0;
    int         max_sig = 96;

    int         words_queued = 0;
    int         errors = 0;
    int         src_idle_pct = 0;
    int         sink_idle_pct = 0;
    bit         hold_armed = 1'b0;
    int         hold_cnt = 0;
    logic       sink_hold;
    int         cycle_cnt = 0;

    assign sink_hold = hold_armed && (hold_cnt < HOLD_CYCLES);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_store();
        held_cnt  = 0;
        head_ptr  = 0;
        draining  = 1'b0;
        drain_pos = 0;
        sig_hold  = 0;
        img_hold  = 0;
    endfunction

    function automatic void split_step(logic [1:0] mode, logic [7:0] data);
        t_result r;
        bit      gives;
        int      len;
        int      total;
        r      = '0;
        r.kind = KIND_STATUS;
        r.status = ST_OK;
        gives  = 1'b1;
        case (mode)
            MODE_PUSH: begin
                if (draining) begin
                    r.status = ST_REFUSED;
                end else if (held_cnt < DEPTH) begin
                    held_bytes[(head_ptr + held_cnt) % DEPTH] = data;
                    held_cnt++;
                    gives = 1'b0;
                end else begin
                    // full store: oldest byte falls out as released
                    r.kind     = KIND_RELEASED;
                    r.byte_out = held_bytes[head_ptr];
                    held_bytes[head_ptr] = data;
                    head_ptr = (head_ptr + 1) % DEPTH;
                end
            end
            MODE_END: begin
                if (draining) begin
                    r.status = ST_REFUSED;
                end else if (held_cnt < 2) begin
                    clear_store();
                    r.status = ST_TOO_SHORT;
                end else begin
                    len = int'({held_bytes[(head_ptr + held_cnt - 2) % DEPTH],
                                held_bytes[(head_ptr + held_cnt - 1) % DEPTH]});
                    if (len == 0 || len > max_sig || len + 2 > held_cnt) begin
                        clear_store();
                        r.status = ST_MALFORMED;
                    end else begin
                        sig_hold  = len;
                        img_hold  = held_cnt - 2 - len;
                        drain_pos = 0;
                        draining  = 1'b1;
                        r.sig_len = sig_hold[7:0];
                        r.img_len = img_hold[7:0];
                    end
                end
            end
            MODE_DRAIN: begin
                if (!draining) begin
                    r.status = ST_EMPTY;
                end else begin
                    total      = img_hold + sig_hold;
                    r.byte_out = held_bytes[(head_ptr + drain_pos) % DEPTH];
                    if (drain_pos < img_hold) begin
                        r.kind = KIND_IMAGE;
                        drain_pos++;
                    end else begin
                        r.kind = KIND_SIGNATURE;
                        if (drain_pos + 1 >= total) begin
                            r.last = 1'b1;
                            clear_store();
                        end else begin
                            drain_pos++;
                        end
                    end
                end
            end
            default: gives = 1'b0;
        endcase
        if (gives)
            pending_results.push_back(r);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                split_step(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (stream_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_word = stream_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_word.mode;
                    s_axis_tdata  <= next_word.data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink hold-off counter
    always @(posedge i_clk) begin
        if (sink_hold)
            hold_cnt <= hold_cnt + 1;
    end

    // monitor
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("unexpected word: kind %0d byte %02h tdata %08h last %0b",
                             m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.kind || m_axis_tdata[7:0] != want.byte_out ||
                    m_axis_tdata[10:8] != want.status || m_axis_tdata[18:11] != want.sig_len ||
                    m_axis_tdata[26:19] != want.img_len || m_axis_tlast != want.last) begin
                    errors++;
                    if (errors <= SHOW_MAX) begin
                        $display("mismatch: exp kind %0d byte %02h st %0d sig %0d img %0d last %0b",
                                 want.kind, want.byte_out, want.status, want.sig_len,
                                 want.img_len, want.last);
                        $display("          got kind %0d byte %02h st %0d sig %0d img %0d last %0b",
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                                 m_axis_tdata[18:11], m_axis_tdata[26:19], m_axis_tlast);
                    end
                end
            end
        end
        m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("timeout with %0d words expected", pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic put(logic [1:0] mode, logic [7:0] data);
        t_stream_word w;
        w.mode = mode;
        w.data = data;
        stream_words.push_back(w);
        if (mode != MODE_IGNORED)
            words_queued++;
    endtask

    // one stream: image, signature, footer (or at most one byte), end, then drains if it parses
    task automatic add_stream();
        int img;
        int sig;
        int cap;
        int foot;
        int shape;
        int n;
        int held;
        cap   = (max_sig > DEPTH - 2) ? DEPTH - 2 : max_sig;
        img   = ($urandom_range(19) == 0) ? $urandom_range(150, 300) : $urandom_range(12);
        sig   = ($urandom_range(5) == 0) ? $urandom_range(1, cap)
                                         : $urandom_range(1, (cap < 8) ? cap : 8);
        foot  = sig;
        shape = $urandom_range(11);
        case (shape)
            0: foot = $urandom_range(65535);
            1: foot = 0;
            2: foot = max_sig + $urandom_range(1, 3);
            3: foot = sig + img + 1 + $urandom_range(2);
            default: ;
        endcase
        n = 0;
        if (shape == 4) begin
            // too short: zero or one byte before end
            if ($urandom_range(1)) begin
                put(MODE_PUSH, 8'($urandom_range(255)));
                n = 1;
            end
        end else begin
            repeat (img + sig) begin
                if ($urandom_range(30) == 0)
                    put($urandom_range(1) ? MODE_IGNORED : MODE_DRAIN,
                        8'($urandom_range(255)));
                put(MODE_PUSH, 8'($urandom_range(255)));
                n++;
            end
            put(MODE_PUSH, foot[15:8]);
            put(MODE_PUSH, foot[7:0]);
            n += 2;
        end
        put(MODE_END, 8'($urandom_range(255)));
        held = (n > DEPTH) ? DEPTH : n;
        if (held >= 2 && foot != 0 && foot <= max_sig && foot + 2 <= held) begin
            repeat (held - 2) begin
                if ($urandom_range(15) == 0)
                    put($urandom_range(1) ? MODE_PUSH : MODE_END, 8'($urandom_range(255)));
                put(MODE_DRAIN, 8'($urandom_range(255)));
            end
            if ($urandom_range(3) == 0)
                put(MODE_DRAIN, 8'($urandom_range(255)));
        end
    endtask

    task automatic wait_quiet();
        while (stream_words.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
        // pushes into a non-full store leave no word behind
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic run_phase(int cfg, int src_pct, int sink_pct, int budget);
        int start;
        wait_quiet();
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= cfg[7:0];
        src_idle_pct  <= src_pct;
        sink_idle_pct <= sink_pct;
        max_sig = cfg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        start = words_queued;
        while (words_queued - start < budget)
            add_stream();
    endtask

    initial begin
        foreach (held_bytes[k])
            held_bytes[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(96, 18, 53, 0);
        put(MODE_DRAIN, 8'h00);                         // nothing to drain
        put(MODE_END, 8'hFF);                           // empty store
        put(MODE_PUSH, 8'hFF);
        put(MODE_END, 8'h00);                           // one byte only
        put(MODE_PUSH, 8'h00);
        put(MODE_PUSH, 8'h00);
        put(MODE_END, 8'h00);                           // zero length
        put(MODE_PUSH, 8'h00);
        put(MODE_PUSH, 8'h61);
        put(MODE_END, 8'h00);                           // above register
        put(MODE_PUSH, 8'hAB);
        put(MODE_PUSH, 8'h00);
        put(MODE_PUSH, 8'h02);
        put(MODE_END, 8'h00);                           // longer than held
        put(MODE_PUSH, 8'h11);
        put(MODE_PUSH, 8'hFF);
        put(MODE_PUSH, 8'h00);
        put(MODE_PUSH, 8'h01);
        put(MODE_END, 8'h00);                           // good footer
        put(MODE_PUSH, 8'h55);                          // refused
        put(MODE_END, 8'hAA);                           // refused
        put(MODE_IGNORED, 8'hC3);
        put(MODE_DRAIN, 8'h00);
        put(MODE_DRAIN, 8'h00);                         // last signature byte
        put(MODE_DRAIN, 8'h00);

        run_phase(1, 18, 53, 70);
        hold_armed <= 1'b1;
        run_phase(158, 18, 53, 70);
        run_phase($urandom_range(1, 158), 53, 18, 70);
        run_phase(96, 53, 18, 70);
        run_phase($urandom_range(1, 158), 0, 0, 70);
        run_phase(158, 0, 0, 70);
        wait_quiet();

        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d words outstanding", errors, pending_results.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
